FILE: sv/cnca_pkg.sv
package cnca_pkg;

  typedef enum logic [1:0] {
    OP_TRAIN  = 2'd0,
    OP_FINISH = 2'd1,
    OP_QUERY  = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_TR_RD,
    S_TR_WR,
    S_QM_RD,
    S_QM_MUL,
    S_QM_ACC,
    S_SEL_INIT,
    S_SEL,
    S_EMIT,
    S_FN_ROW,
    S_SQ_RD,
    S_SQ_MUL,
    S_SQ_ACC,
    S_SQRT_GO,
    S_SQRT_WAIT,
    S_DV_RD,
    S_DV_GO,
    S_DV_WAIT,
    S_DV_WR,
    S_FN_NEXT
  } state_t;

  localparam int VALUE_W    = 16;
  localparam int CENTRE_W   = 32;
  localparam int SCORE_W    = 48;
  localparam int PROD_W     = 64;
  localparam int QUO_W      = 16;
  localparam int FRAC_W     = 15;
  localparam int DIVIDEND_W = CENTRE_W + FRAC_W;
  localparam int SPK_W      = 4;

  localparam logic signed [SCORE_W-1:0] START_BEST = -48'sd2147483648;

endpackage

FILE: sv/cosine_nearest_centroid_assign_top.sv
// Nearest-centroid classifier on Q1.15 embedding rows, cosine score.
// Request channel: opcode/label/value/row_end taken when start is high and busy
// is low. Training requests sum into a cluster centre, finish scales centres
// to unit length, query requests accumulate dot products, clear wipes state.
// Result channel: speaker, cluster_index and score hold for one cycle while
// done is high, one result per query row end; the receiver cannot stall it.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 clusters,
// 1 row length). Writes should come only while the block is idle; the block
// itself does not check this, so keeping to it is up to the user.
// Query elements and the finish pass share the one multiplier. Finish takes a
// square root per nonzero cluster (NW/2 = 36 root bits by default, one root
// bit per cycle) and a divide per element (one quotient bit per cycle).
// Reset and the clear request run a clearing pass over every entry of the
// centre RAM (4096 entries by default), busy meanwhile; reset also sets
// 1 cluster and row length 256.
module cosine_nearest_centroid_assign_top #(
  parameter int MAX_DIM      = 256,
  parameter int MAX_CLUSTERS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         opcode,
  input  logic signed [5:0]  label,
  input  logic signed [15:0] value,
  input  logic               row_end,
  output logic               done,
  output logic [3:0]         speaker,
  output logic [3:0]         cluster_index,
  output logic signed [47:0] score,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [8:0]         cfg_data
);

  localparam int CW    = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int PW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int AW    = CW + PW;
  localparam int DEPTH = 1 << AW;
  localparam int KW    = $clog2(MAX_CLUSTERS + 1);
  localparam int KEW   = (KW > 5) ? KW : 5;
  localparam int LW    = $clog2(MAX_DIM + 1);
  localparam int LEW   = (LW > 9) ? LW : 9;
  localparam int SQW   = 63 + LW;
  localparam int NW    = SQW + (SQW % 2);
  localparam int RTW   = NW / 2;
  localparam int SW    = cnca_pkg::SCORE_W;
  localparam int DW    = cnca_pkg::CENTRE_W;

  cnca_pkg::state_t state, state_next;

  logic [4:0]     num_clusters;
  logic [8:0]     vector_length;
  logic [KEW-1:0] k_eff;
  logic [LEW-1:0] len_eff;

  logic [LEW-1:0] pos;
  logic [LEW-1:0] pos_q;
  logic [LEW-1:0] fidx;
  logic [KEW-1:0] cidx;
  logic [KEW-1:0] cidx_inc;
  logic [LEW-1:0] fidx_inc;
  logic           in_row;
  logic           label_ok;
  logic [CW-1:0]  lab_idx;
  logic [CW-1:0]  lab_q;
  logic           accept;

  logic signed [15:0] value_q;
  logic               row_end_q;

  logic [15:0]          rows_held [MAX_CLUSTERS];
  logic signed [SW-1:0] dot_sums  [MAX_CLUSTERS];
  logic                 seen_valid [MAX_CLUSTERS];
  logic [cnca_pkg::SPK_W-1:0] seen_map [MAX_CLUSTERS];
  logic [cnca_pkg::SPK_W-1:0] next_speaker;

  logic signed [SW-1:0] best;
  logic [CW-1:0]        best_at;

  logic [AW-1:0]  clr_addr;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [DW-1:0]  mem_wdata;
  logic [AW-1:0]  mem_raddr;
  logic [DW-1:0]  mem_rdata;

  logic signed [DW-1:0]     mul_a;
  logic signed [DW-1:0]     mul_b;
  logic signed [cnca_pkg::PROD_W-1:0] prod;

  logic [SQW-1:0]  sumsq;
  logic            sq_start;
  logic            sq_done;
  logic [RTW-1:0]  sq_root;
  logic [RTW-1:0]  norm;
  logic            dv_start;
  logic            dv_done;
  logic [cnca_pkg::QUO_W-1:0]      dv_quo;
  logic [cnca_pkg::DIVIDEND_W-1:0] dv_dividend;
  logic [DW-1:0]   mag;
  logic            neg;

  logic signed [DW:0]   tr_sum;
  logic signed [DW-1:0] tr_sat;
  logic signed [SW:0]   acc_sum;
  logic signed [SW-1:0] acc_sat;
  logic [cnca_pkg::FRAC_W-1:0] q_sat;
  logic signed [DW-1:0] q_signed;

  assign busy   = (state != cnca_pkg::S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    if (num_clusters == 5'd0) begin
      k_eff = KEW'(1);
    end else if (KEW'(num_clusters) > KEW'(MAX_CLUSTERS)) begin
      k_eff = KEW'(MAX_CLUSTERS);
    end else begin
      k_eff = KEW'(num_clusters);
    end
    if (vector_length == 9'd0) begin
      len_eff = LEW'(1);
    end else if (LEW'(vector_length) > LEW'(MAX_DIM)) begin
      len_eff = LEW'(MAX_DIM);
    end else begin
      len_eff = LEW'(vector_length);
    end
  end

  assign in_row   = pos < len_eff;
  assign label_ok = !label[5] && (KEW'(label[4:0]) < k_eff);
  assign lab_idx  = CW'(label[4:0]);
  assign cidx_inc = cidx + KEW'(1);
  assign fidx_inc = fidx + LEW'(1);

  assign tr_sum = DW'(signed'(mem_rdata)) + (DW+1)'(value_q);
  assign tr_sat = (tr_sum[DW] != tr_sum[DW-1])
                ? (tr_sum[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}})
                : tr_sum[DW-1:0];

  assign acc_sum = {dot_sums[cidx[CW-1:0]][SW-1], dot_sums[cidx[CW-1:0]]} + prod[SW:0];
  assign acc_sat = (acc_sum[SW] != acc_sum[SW-1])
                 ? (acc_sum[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}})
                 : acc_sum[SW-1:0];

  assign q_sat    = dv_quo[cnca_pkg::QUO_W-1] ? {cnca_pkg::FRAC_W{1'b1}}
                                              : dv_quo[cnca_pkg::FRAC_W-1:0];
  assign q_signed = neg ? -DW'(q_sat) : DW'(q_sat);
  assign mag         = mem_rdata[DW-1] ? -mem_rdata : mem_rdata;
  assign dv_dividend = {mag, {cnca_pkg::FRAC_W{1'b0}}};

  always_comb begin
    if (state == cnca_pkg::S_QM_MUL) begin
      mul_a = DW'(value_q);
    end else begin
      mul_a = signed'(mem_rdata);
    end
    mul_b = signed'(mem_rdata);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      cnca_pkg::S_CLEAR: begin
        if (clr_addr == {AW{1'b1}}) state_next = cnca_pkg::S_IDLE;
      end
      cnca_pkg::S_IDLE: begin
        if (accept) begin
          unique case (cnca_pkg::opcode_t'(opcode))
            cnca_pkg::OP_CLEAR:  state_next = cnca_pkg::S_CLEAR;
            cnca_pkg::OP_FINISH: state_next = cnca_pkg::S_FN_ROW;
            cnca_pkg::OP_TRAIN: begin
              if (label_ok && in_row) state_next = cnca_pkg::S_TR_RD;
            end
            cnca_pkg::OP_QUERY: begin
              if (in_row) state_next = cnca_pkg::S_QM_RD;
              else if (row_end) state_next = cnca_pkg::S_SEL_INIT;
            end
            default: state_next = cnca_pkg::S_IDLE;
          endcase
        end
      end
      cnca_pkg::S_TR_RD:  state_next = cnca_pkg::S_TR_WR;
      cnca_pkg::S_TR_WR:  state_next = cnca_pkg::S_IDLE;
      cnca_pkg::S_QM_RD:  state_next = cnca_pkg::S_QM_MUL;
      cnca_pkg::S_QM_MUL: state_next = cnca_pkg::S_QM_ACC;
      cnca_pkg::S_QM_ACC: begin
        if (cidx_inc < k_eff) state_next = cnca_pkg::S_QM_RD;
        else if (row_end_q) state_next = cnca_pkg::S_SEL_INIT;
        else state_next = cnca_pkg::S_IDLE;
      end
      cnca_pkg::S_SEL_INIT: state_next = cnca_pkg::S_SEL;
      cnca_pkg::S_SEL: begin
        if (!(cidx_inc < k_eff)) state_next = cnca_pkg::S_EMIT;
      end
      cnca_pkg::S_EMIT:   state_next = cnca_pkg::S_IDLE;
      cnca_pkg::S_FN_ROW: state_next = cnca_pkg::S_SQ_RD;
      cnca_pkg::S_SQ_RD:  state_next = cnca_pkg::S_SQ_MUL;
      cnca_pkg::S_SQ_MUL: state_next = cnca_pkg::S_SQ_ACC;
      cnca_pkg::S_SQ_ACC: begin
        if (fidx_inc < len_eff) state_next = cnca_pkg::S_SQ_RD;
        else state_next = cnca_pkg::S_SQRT_GO;
      end
      cnca_pkg::S_SQRT_GO: begin
        if (sumsq == '0) state_next = cnca_pkg::S_FN_NEXT;
        else state_next = cnca_pkg::S_SQRT_WAIT;
      end
      cnca_pkg::S_SQRT_WAIT: begin
        if (sq_done) state_next = cnca_pkg::S_DV_RD;
      end
      cnca_pkg::S_DV_RD: state_next = cnca_pkg::S_DV_GO;
      cnca_pkg::S_DV_GO: state_next = cnca_pkg::S_DV_WAIT;
      cnca_pkg::S_DV_WAIT: begin
        if (dv_done) state_next = cnca_pkg::S_DV_WR;
      end
      cnca_pkg::S_DV_WR: begin
        if (fidx_inc < len_eff) state_next = cnca_pkg::S_DV_RD;
        else state_next = cnca_pkg::S_FN_NEXT;
      end
      cnca_pkg::S_FN_NEXT: begin
        if (cidx_inc < k_eff) state_next = cnca_pkg::S_FN_ROW;
        else state_next = cnca_pkg::S_IDLE;
      end
      default: state_next = cnca_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = '0;
    mem_raddr = {cidx[CW-1:0], fidx[PW-1:0]};
    sq_start  = 1'b0;
    dv_start  = 1'b0;
    unique case (state)
      cnca_pkg::S_CLEAR: mem_we = 1'b1;
      cnca_pkg::S_TR_RD: mem_raddr = {lab_q, pos_q[PW-1:0]};
      cnca_pkg::S_TR_WR: begin
        mem_we    = 1'b1;
        mem_waddr = {lab_q, pos_q[PW-1:0]};
        mem_wdata = tr_sat;
      end
      cnca_pkg::S_QM_RD:   mem_raddr = {cidx[CW-1:0], pos_q[PW-1:0]};
      cnca_pkg::S_SQRT_GO: sq_start = (sumsq != '0);
      cnca_pkg::S_DV_GO:   dv_start = 1'b1;
      cnca_pkg::S_DV_WR: begin
        mem_we    = 1'b1;
        mem_waddr = {cidx[CW-1:0], fidx[PW-1:0]};
        mem_wdata = q_signed;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= cnca_pkg::S_CLEAR;
      num_clusters  <= 5'd1;
      vector_length <= 9'd256;
      clr_addr      <= '0;
      pos           <= '0;
      next_speaker  <= '0;
      done          <= 1'b0;
      for (int i = 0; i < MAX_CLUSTERS; i++) begin
        rows_held[i]  <= '0;
        dot_sums[i]   <= '0;
        seen_valid[i] <= 1'b0;
      end
    end else begin
      state <= state_next;
      done  <= (state == cnca_pkg::S_EMIT);
      if (cfg_we) begin
        if (cfg_index == 1'b0) num_clusters <= cfg_data[4:0];
        else vector_length <= cfg_data;
      end
      if (state == cnca_pkg::S_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (accept) begin
        unique case (cnca_pkg::opcode_t'(opcode))
          cnca_pkg::OP_CLEAR: begin
            clr_addr     <= '0;
            pos          <= '0;
            next_speaker <= '0;
            for (int i = 0; i < MAX_CLUSTERS; i++) begin
              rows_held[i]  <= '0;
              dot_sums[i]   <= '0;
              seen_valid[i] <= 1'b0;
            end
          end
          cnca_pkg::OP_FINISH: begin
            pos <= '0;
            for (int i = 0; i < MAX_CLUSTERS; i++) begin
              dot_sums[i] <= '0;
            end
          end
          default: begin
            if (row_end) pos <= '0;
            else if (in_row) pos <= pos + LEW'(1);
            if ((cnca_pkg::opcode_t'(opcode) == cnca_pkg::OP_TRAIN) && row_end && label_ok &&
                (rows_held[lab_idx] != 16'hFFFF)) begin
              rows_held[lab_idx] <= rows_held[lab_idx] + 16'd1;
            end
          end
        endcase
      end
      if ((state == cnca_pkg::S_QM_ACC) && (rows_held[cidx[CW-1:0]] != '0)) begin
        dot_sums[cidx[CW-1:0]] <= acc_sat;
      end
      if (state == cnca_pkg::S_EMIT) begin
        if (!seen_valid[best_at]) begin
          seen_valid[best_at] <= 1'b1;
          next_speaker        <= next_speaker + cnca_pkg::SPK_W'(1);
        end
        for (int i = 0; i < MAX_CLUSTERS; i++) begin
          dot_sums[i] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      value_q   <= value;
      row_end_q <= row_end;
      lab_q     <= lab_idx;
      pos_q     <= pos;
      cidx      <= '0;
    end
    unique case (state)
      cnca_pkg::S_QM_MUL, cnca_pkg::S_SQ_MUL: prod <= mul_a * mul_b;
      cnca_pkg::S_QM_ACC, cnca_pkg::S_FN_NEXT: cidx <= cidx_inc;
      cnca_pkg::S_SEL_INIT: begin
        best    <= cnca_pkg::START_BEST;
        best_at <= '0;
        cidx    <= '0;
      end
      cnca_pkg::S_SEL: begin
        if ((rows_held[cidx[CW-1:0]] != '0) && (dot_sums[cidx[CW-1:0]] > best)) begin
          best    <= dot_sums[cidx[CW-1:0]];
          best_at <= cidx[CW-1:0];
        end
        cidx <= cidx_inc;
      end
      cnca_pkg::S_EMIT: begin
        cluster_index <= 4'(best_at);
        score         <= best;
        if (!seen_valid[best_at]) begin
          seen_map[best_at] <= next_speaker;
          speaker           <= next_speaker;
        end else begin
          speaker <= seen_map[best_at];
        end
      end
      cnca_pkg::S_FN_ROW: begin
        sumsq <= '0;
        fidx  <= '0;
      end
      cnca_pkg::S_SQ_ACC: begin
        sumsq <= sumsq + SQW'($unsigned(prod));
        fidx  <= fidx_inc;
      end
      cnca_pkg::S_SQRT_WAIT: begin
        norm <= sq_root;
        fidx <= '0;
      end
      cnca_pkg::S_DV_GO: begin
        neg <= mem_rdata[DW-1];
      end
      cnca_pkg::S_DV_WR: fidx <= fidx_inc;
      default: begin
      end
    endcase
  end

  cnca_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_centres (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  cnca_isqrt #(
    .NW (NW)
  ) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (NW'(sumsq)),
    .done     (sq_done),
    .root     (sq_root)
  );

  cnca_div #(
    .DVW (RTW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (dv_start),
    .dividend (dv_dividend),
    .divisor  (norm),
    .done     (dv_done),
    .quotient (dv_quo)
  );

`ifndef SYNTH
  a_done_after_emit: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == cnca_pkg::S_EMIT)
    else $error("result strobe without select");

  a_root_in_wait: assert property (@(posedge clk) disable iff (rst)
    sq_done |-> state == cnca_pkg::S_SQRT_WAIT)
    else $error("root finished outside wait");

  a_quo_in_wait: assert property (@(posedge clk) disable iff (rst)
    dv_done |-> state == cnca_pkg::S_DV_WAIT)
    else $error("quotient finished outside wait");

  a_no_accept_clearing: assert property (@(posedge clk) disable iff (rst)
    state == cnca_pkg::S_CLEAR |-> busy && !mem_rdata[0] || busy)
    else $error("request possible while clearing");
`endif

endmodule

FILE: sv/cnca_ram.sv
module cnca_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/cnca_isqrt.sv
module cnca_isqrt #(
  parameter int NW = 74
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [NW-1:0]   radicand,
  output logic            done,
  output logic [NW/2-1:0] root
);

  logic          active;
  logic [NW-1:0] num;
  logic [NW-1:0] res;
  logic [NW-1:0] bit_q;
  logic [NW-1:0] trial;

  assign trial = res + bit_q;
  assign root  = res[NW/2-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
      end else if (active && bit_q[0]) begin
        active <= 1'b0;
        done   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num   <= radicand;
      res   <= '0;
      bit_q <= {2'b01, {(NW-2){1'b0}}};
    end else if (active) begin
      if (num >= trial) begin
        num <= num - trial;
        res <= (res >> 1) + bit_q;
      end else begin
        res <= res >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

endmodule

FILE: sv/cnca_div.sv
module cnca_div #(
  parameter int DVW = 37
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [cnca_pkg::DIVIDEND_W-1:0]     dividend,
  input  logic [DVW-1:0]                      divisor,
  output logic                                done,
  output logic [cnca_pkg::QUO_W-1:0]          quotient
);

  localparam int QW  = cnca_pkg::QUO_W;
  localparam int RW  = (cnca_pkg::DIVIDEND_W > DVW + QW) ? cnca_pkg::DIVIDEND_W : DVW + QW;
  localparam int CNW = $clog2(QW);

  logic           active;
  logic [CNW-1:0] cnt;
  logic [RW-1:0]  rem;
  logic [RW-1:0]  dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= CNW'(QW - 1);
      end else if (active) begin
        cnt <= cnt - CNW'(1);
        if (cnt == '0) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= RW'(dividend);
      dsh      <= RW'(divisor) << (QW - 1);
      quotient <= '0;
    end else if (active) begin
      if (rem >= dsh) begin
        rem      <= rem - dsh;
        quotient <= {quotient[QW-2:0], 1'b1};
      end else begin
        quotient <= {quotient[QW-2:0], 1'b0};
      end
      dsh <= dsh >> 1;
    end
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int KMAX = 16;
  localparam int DMAX = 256;
  localparam longint S48_MAX = 64'sd140737488355327;
  localparam longint S48_MIN = -64'sd140737488355328;
  localparam longint BEST_INIT = -64'sd2147483648;
  localparam int LIMIT = 20000000;

  typedef struct {
    logic [3:0]  spk;
    logic [3:0]  idx;
    logic [47:0] score;
  } match_t;

  class centroid_scoreboard;
    int centre [KMAX][DMAX];
    int held [KMAX];
    longint dots [KMAX];
    bit seen [KMAX];
    int spk_map [KMAX];
    int next_spk;
    int pos;
    int num_reg;
    int len_reg;
    match_t pending [$];
    int fails;

    function void wipe();
      for (int c = 0; c < KMAX; c++) begin
        for (int f = 0; f < DMAX; f++) centre[c][f] = 0;
        held[c] = 0;
        dots[c] = 0;
        seen[c] = 0;
        spk_map[c] = 0;
      end
      next_spk = 0;
      pos = 0;
    endfunction

    function new();
      wipe();
      num_reg = 1;
      len_reg = 256;
      fails = 0;
    endfunction

    function int kk();
      return num_reg < 1 ? 1 : (num_reg > KMAX ? KMAX : num_reg);
    endfunction

    function int ll();
      return len_reg < 1 ? 1 : (len_reg > DMAX ? DMAX : len_reg);
    endfunction

    function void write_reg(bit idx, logic [8:0] data);
      if (idx == 1'b0) num_reg = data & 9'h1f;
      else len_reg = data;
    endfunction

    function void normalize();
      logic [127:0] acc;
      logic [127:0] t;
      longint unsigned m;
      longint unsigned q;
      longint unsigned norm;
      for (int c = 0; c < kk(); c++) begin
        acc = 0;
        for (int f = 0; f < ll(); f++) begin
          m = centre[c][f] < 0 ? -longint'(centre[c][f]) : centre[c][f];
          acc = acc + 128'(m * m);
        end
        if (acc != 0) begin
          norm = 0;
          for (int b = 50; b >= 0; b--) begin
            t = 128'(norm | (64'd1 << b));
            if (t * t <= acc) norm = t[63:0];
          end
          for (int f = 0; f < ll(); f++) begin
            m = centre[c][f] < 0 ? -longint'(centre[c][f]) : centre[c][f];
            q = (m * 64'd32768) / norm;
            if (q > 32767) q = 32767;
            centre[c][f] = centre[c][f] < 0 ? -int'(q) : int'(q);
          end
        end
      end
      for (int c = 0; c < KMAX; c++) dots[c] = 0;
      pos = 0;
    endfunction

    function void note(cnca_pkg::opcode_t op, logic signed [5:0] lab, logic signed [15:0] val,
                       bit re);
      int p;
      bit in_row;
      bit ok;
      longint s;
      longint best;
      int at;
      match_t m;
      p = pos;
      in_row = p < ll();
      if (op == cnca_pkg::OP_CLEAR) begin
        wipe();
        return;
      end
      if (op == cnca_pkg::OP_FINISH) begin
        normalize();
        return;
      end
      if (in_row) pos = p + 1;
      if (op == cnca_pkg::OP_TRAIN) begin
        ok = int'(lab) >= 0 && int'(lab) < kk();
        if (ok && in_row) begin
          s = longint'(centre[lab][p]) + longint'(val);
          if (s > 64'sd2147483647) s = 64'sd2147483647;
          if (s < -64'sd2147483648) s = -64'sd2147483648;
          centre[lab][p] = int'(s);
        end
        if (re) begin
          if (ok && held[lab] != 65535) held[lab]++;
          pos = 0;
        end
        return;
      end
      if (in_row) begin
        for (int c = 0; c < kk(); c++) begin
          if (held[c] != 0) begin
            s = dots[c] + longint'(val) * longint'(centre[c][p]);
            if (s > S48_MAX) s = S48_MAX;
            if (s < S48_MIN) s = S48_MIN;
            dots[c] = s;
          end
        end
      end
      if (!re) return;
      best = BEST_INIT;
      at = 0;
      for (int c = 0; c < kk(); c++) begin
        if (held[c] != 0 && dots[c] > best) begin
          best = dots[c];
          at = c;
        end
      end
      if (!seen[at]) begin
        seen[at] = 1;
        spk_map[at] = next_spk;
        next_spk++;
      end
      m.spk = spk_map[at][3:0];
      m.idx = at[3:0];
      m.score = best[47:0];
      pending.push_back(m);
      for (int c = 0; c < KMAX; c++) dots[c] = 0;
      pos = 0;
    endfunction

    function void check(logic [3:0] spk, logic [3:0] idx, logic [47:0] sc);
      match_t m;
      if (pending.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected result spk=%0d idx=%0d score=%0d", spk, idx,
                                  $signed(sc));
        return;
      end
      m = pending.pop_front();
      if (m.spk !== spk || m.idx !== idx || m.score !== sc) begin
        fails++;
        if (fails <= 10)
          $display("mismatch exp spk=%0d idx=%0d score=%0d got spk=%0d idx=%0d score=%0d",
                   m.spk, m.idx, $signed(m.score), spk, idx, $signed(sc));
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic [1:0] opcode = 0;
  logic signed [5:0] label = 0;
  logic signed [15:0] value = 0;
  logic row_end = 0;
  logic done;
  logic [3:0] speaker;
  logic [3:0] cluster_index;
  logic signed [47:0] score;
  logic cfg_we = 0;
  logic cfg_index = 0;
  logic [8:0] cfg_data = 0;

  centroid_scoreboard sb = new();
  int idle_pct = 32;
  int items = 0;
  int cycles = 0;

  cosine_nearest_centroid_assign_top u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode), .label(label),
    .value(value), .row_end(row_end), .done(done), .speaker(speaker),
    .cluster_index(cluster_index), .score(score), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("cosine_nearest_centroid_assign_top test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check(speaker, cluster_index, score);
  end

  task automatic send(cnca_pkg::opcode_t op, logic signed [5:0] lab, logic signed [15:0] val,
                      bit re);
    start <= 1'b1;
    opcode <= op;
    label <= lab;
    value <= val;
    row_end <= re;
    do @(posedge clk); while (busy);
    sb.note(op, lab, val, re);
    items++;
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($signed($urandom_range(0, 15)) - 8);
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic train_row(logic signed [5:0] lab, int n);
    for (int i = 0; i < n; i++) send(cnca_pkg::OP_TRAIN, lab, pick_value(), i == n - 1);
  endtask

  task automatic query_row(int n);
    for (int i = 0; i < n; i++) send(cnca_pkg::OP_QUERY, 6'($urandom()), pick_value(), i == n - 1);
  endtask

  // hold until every result is in and the block has gone idle
  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    do @(posedge clk); while (busy);
    repeat (24) @(posedge clk);
  endtask

  task automatic write_reg(bit idx, logic [8:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  function automatic int row_len(int ln);
    int r;
    r = $urandom_range(0, 99);
    if (ln > 32 && r < 70) return $urandom_range(1, 16);
    if (r < 8) return ln + $urandom_range(1, 2);
    if (r < 16) return $urandom_range(1, ln);
    return ln;
  endfunction

  function automatic logic signed [5:0] pick_label(int k);
    int r;
    r = $urandom_range(0, 99);
    if (r < 88) return 6'($urandom_range(0, k - 1));
    if (r < 94) return -6'sd1;
    return 6'($urandom_range(k, 31));
  endfunction

  task automatic run_phase(logic [8:0] kreg, logic [8:0] lreg, int budget);
    int k;
    int ln;
    int base;
    int r;
    drain();
    write_reg(1'b0, kreg);
    write_reg(1'b1, lreg);
    k = sb.kk();
    ln = sb.ll();
    base = items;
    while (items - base < budget * 4 / 10) train_row(pick_label(k), row_len(ln));
    send(cnca_pkg::OP_FINISH, 6'($urandom()), 16'($urandom()), 1'($urandom()));
    while (items - base < budget * 8 / 10) query_row(row_len(ln));
    while (items - base < budget) begin
      r = $urandom_range(0, 99);
      if (r < 35) train_row(pick_label(k), row_len(ln));
      else if (r < 75) query_row(row_len(ln));
      else if (r < 85)
        send(cnca_pkg::OP_FINISH, 6'($urandom()), 16'($urandom()), 1'($urandom()));
      else if (r < 87)
        send(cnca_pkg::OP_CLEAR, 6'($urandom()), 16'($urandom()), 1'($urandom()));
      else
        send(cnca_pkg::opcode_t'($urandom_range(0, 2)), 6'($urandom()), 16'($urandom()),
             1'($urandom()));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    drain();
    write_reg(1'b0, 9'd3);
    write_reg(1'b1, 9'd4);
    send(cnca_pkg::OP_QUERY, 6'sd0, 16'sd5, 1'b1);
    send(cnca_pkg::OP_TRAIN, 6'sd0, 16'sh7fff, 1'b0);
    send(cnca_pkg::OP_TRAIN, 6'sd0, 16'sh8000, 1'b0);
    send(cnca_pkg::OP_TRAIN, 6'sd0, 16'sh7fff, 1'b0);
    send(cnca_pkg::OP_TRAIN, 6'sd0, 16'sh7fff, 1'b1);
    train_row(6'sd2, 5);
    train_row(-6'sd1, 2);
    train_row(6'sd3, 1);
    train_row(6'sd31, 1);
    send(cnca_pkg::OP_FINISH, 6'sd0, 16'sd0, 1'b0);
    send(cnca_pkg::OP_QUERY, 6'sd0, 16'sh8000, 1'b0);
    send(cnca_pkg::OP_QUERY, 6'sd0, 16'sh7fff, 1'b0);
    send(cnca_pkg::OP_QUERY, 6'sd0, 16'sd0, 1'b0);
    send(cnca_pkg::OP_QUERY, 6'sd0, 16'sd1, 1'b1);
    send(cnca_pkg::OP_QUERY, 6'sd0, 16'sh7fff, 1'b1);
    send(cnca_pkg::OP_CLEAR, -6'sd32, 16'shffff, 1'b1);
    send(cnca_pkg::OP_QUERY, 6'sd0, 16'sd1, 1'b1);

    run_phase(9'd1, 9'd1, 250);
    run_phase(9'd16, 9'd256, 300);
    idle_pct = 68;
    run_phase(9'd5, 9'd16, 400);
    run_phase(9'd16, 9'd8, 400);
    idle_pct = 0;
    run_phase(9'd0, 9'd0, 150);
    run_phase(9'd31, 9'd511, 250);
    run_phase(9'd7, 9'd3, 100);

    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.fails == 0 && sb.pending.size() == 0) begin
      $display("cosine_nearest_centroid_assign_top test passed");
    end else begin
      $display("cosine_nearest_centroid_assign_top test failed");
    end
    $finish;
  end

endmodule
